// ===== rtl/flrc_pkg.sv =====
// Package for the row line cache: sizes, widths, configuration register
// indexes and the controller state type.
// No dependencies.
package flrc_pkg;

  localparam int MaxRows  = 4096;
  localparam int MaxSlots = 64;

  localparam int RowW    = 12;
  localparam int SlotW   = $clog2(MaxSlots);
  localparam int CntW    = $clog2(MaxSlots + 1);
  localparam int HdrW    = 24;
  localparam int SampW   = 4;
  localparam int LineW   = 16;
  localparam int OffW    = 32;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 24;

  localparam int SlotsRst  = 64;
  localparam int HdrRst    = 0;
  localparam int SampRst   = 2;
  localparam int LineRst   = 1024;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSlots  = 2'd0,
    CfgHeader = 2'd1,
    CfgSample = 2'd2,
    CfgLine   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StLook,
    StCheck
  } state_e;

endpackage

// ===== rtl/flrc_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module flrc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/flrc_offset.sv =====
// Line offset pipeline: header plus sample size times row times line width,
// saturated to 32 bits. Two product stages, the final add is combinational.
// Depends on flrc_pkg.
module flrc_offset (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [flrc_pkg::RowW-1:0]  row_i,
  input  logic [flrc_pkg::SampW-1:0] sample_i,
  input  logic [flrc_pkg::LineW-1:0] line_i,
  input  logic [flrc_pkg::HdrW-1:0]  header_i,
  output logic [flrc_pkg::OffW-1:0]  offset_o
);
  import flrc_pkg::*;

  localparam int P1W = SampW + RowW;

  logic [P1W-1:0]  prod1_q;
  logic [OffW-1:0] prod2_q;
  logic [OffW:0]   sum;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod1_q <= P1W'(sample_i) * P1W'(row_i);
    end
    prod2_q <= OffW'(prod1_q) * OffW'(line_i);
  end

  assign sum      = {1'b0, prod2_q} + (OffW + 1)'(header_i);
  assign offset_o = sum[OffW] ? '1 : sum[OffW-1:0];

endmodule

// ===== rtl/fifo_row_line_cache.sv =====
// Top level of the row line cache with first-in first-out slot replacement.
// Depends on flrc_pkg, flrc_ram and flrc_offset.
//
//   Channel  | Handshake          | Payload
//   ---------+--------------------+-------------------------------------------
//   request  | start_i / busy_o   | row_i
//   result   | done_o (strobe)    | hit_o slot_o evicted_valid_o evicted_row_o
//            |                    | fetch_offset_o
//   config   | cfg_we_i           | cfg_idx_i cfg_wdata_i
//
// A request passes through the row map read, the slot map read, then the
// hit check with write-back; the result strobe follows in the next cycle,
// when a new request can already be accepted. The two map memories with their
// registered reads set this sequence. After reset every row map entry is
// cleared with busy_o high. Results cannot be stalled.
module fifo_row_line_cache (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [flrc_pkg::RowW-1:0]    row_i,
  input  logic                        cfg_we_i,
  input  logic [flrc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [flrc_pkg::CfgW-1:0]    cfg_wdata_i,
  output logic                        done_o,
  output logic                        hit_o,
  output logic [flrc_pkg::SlotW-1:0]   slot_o,
  output logic                        evicted_valid_o,
  output logic [flrc_pkg::RowW-1:0]    evicted_row_o,
  output logic [flrc_pkg::OffW-1:0]    fetch_offset_o
);
  import flrc_pkg::*;

  localparam int RAddrW = $clog2(MaxRows);

  state_e state_q, state_d;

  logic [CntW-1:0]  slots_q;
  logic [HdrW-1:0]  header_q;
  logic [SampW-1:0] sample_q;
  logic [LineW-1:0] line_q;

  logic [RAddrW-1:0]   clr_cnt_q, clr_cnt_d;
  logic [SlotW-1:0]    next_slot_q, next_slot_d;
  logic [MaxSlots-1:0] slot_vld_q, slot_vld_d;
  logic [RowW-1:0]     row_q;
  logic [SlotW-1:0]    victim_q, victim_d;
  logic [SlotW-1:0]    cand_q;
  logic [RowW-1:0]     vict_row_q;
  logic                vict_vld_q;

  logic                done_q;
  logic                hit_q;
  logic [SlotW-1:0]    slot_q;
  logic                ev_vld_q;
  logic [RowW-1:0]     ev_row_q;
  logic [OffW-1:0]     off_q;

  logic [CntW-1:0]   eff;
  logic [CntW-1:0]   vict_inc;
  logic              accept;
  logic              hit;
  logic [OffW-1:0]   offset;

  logic              rsm_we;
  logic [RAddrW-1:0] rsm_waddr;
  logic [SlotW-1:0]  rsm_wdata;
  logic [SlotW-1:0]  rsm_rdata;
  logic              srm_we;
  logic [SlotW-1:0]  srm_raddr;
  logic [RowW-1:0]   srm_rdata;

  assign accept = start_i && (state_q == StIdle);
  assign busy_o = (state_q != StIdle);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q  <= CntW'(SlotsRst);
      header_q <= HdrW'(HdrRst);
      sample_q <= SampW'(SampRst);
      line_q   <= LineW'(LineRst);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgSlots:  slots_q  <= cfg_wdata_i[CntW-1:0];
        CfgHeader: header_q <= cfg_wdata_i[HdrW-1:0];
        CfgSample: sample_q <= cfg_wdata_i[SampW-1:0];
        CfgLine:   line_q   <= cfg_wdata_i[LineW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (slots_q == '0) begin
      eff = CntW'(1);
    end else if (slots_q > CntW'(MaxSlots)) begin
      eff = CntW'(MaxSlots);
    end else begin
      eff = slots_q;
    end
  end

  assign victim_d = ({1'b0, next_slot_q} < eff) ? next_slot_q : '0;
  assign vict_inc = CntW'(victim_q) + CntW'(1);
  assign hit      = slot_vld_q[cand_q] && (srm_rdata == row_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear: begin
        if (clr_cnt_q == RAddrW'(MaxRows - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (start_i) begin
          state_d = StLook;
        end
      end
      StLook:  state_d = StCheck;
      StCheck: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Memory control and state updates.
  always_comb begin
    rsm_we      = 1'b0;
    rsm_waddr   = RAddrW'(row_q);
    rsm_wdata   = victim_q;
    srm_we      = 1'b0;
    srm_raddr   = victim_d;
    clr_cnt_d   = clr_cnt_q;
    next_slot_d = next_slot_q;
    slot_vld_d  = slot_vld_q;
    case (state_q)
      StClear: begin
        rsm_we    = 1'b1;
        rsm_waddr = clr_cnt_q;
        rsm_wdata = '0;
        clr_cnt_d = clr_cnt_q + RAddrW'(1);
      end
      StIdle: srm_raddr = victim_d;
      StLook: srm_raddr = rsm_rdata;
      StCheck: begin
        if (!hit) begin
          rsm_we               = 1'b1;
          srm_we               = 1'b1;
          slot_vld_d[victim_q] = 1'b1;
          next_slot_d          = (vict_inc >= eff) ? '0 : vict_inc[SlotW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_cnt_q   <= '0;
      next_slot_q <= '0;
      slot_vld_q  <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      next_slot_q <= next_slot_d;
      slot_vld_q  <= slot_vld_d;
      done_q      <= (state_q == StCheck);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_q    <= row_i;
      victim_q <= victim_d;
    end
    if (state_q == StLook) begin
      cand_q     <= rsm_rdata;
      vict_row_q <= srm_rdata;
      vict_vld_q <= slot_vld_q[victim_q];
    end
    if (state_q == StCheck) begin
      hit_q    <= hit;
      slot_q   <= hit ? cand_q : victim_q;
      ev_vld_q <= !hit && vict_vld_q;
      ev_row_q <= (!hit && vict_vld_q) ? vict_row_q : '0;
      off_q    <= hit ? '0 : offset;
    end
  end

  flrc_ram #(
    .Width (SlotW),
    .Depth (MaxRows)
  ) u_row_map (
    .clk_i   (clk_i),
    .we_i    (rsm_we),
    .waddr_i (rsm_waddr),
    .wdata_i (rsm_wdata),
    .raddr_i (RAddrW'(row_i)),
    .rdata_o (rsm_rdata)
  );

  flrc_ram #(
    .Width (RowW),
    .Depth (MaxSlots)
  ) u_slot_map (
    .clk_i   (clk_i),
    .we_i    (srm_we),
    .waddr_i (victim_q),
    .wdata_i (row_q),
    .raddr_i (srm_raddr),
    .rdata_o (srm_rdata)
  );

  flrc_offset u_offset (
    .clk_i    (clk_i),
    .en_i     (accept),
    .row_i    (row_i),
    .sample_i (sample_q),
    .line_i   (line_q),
    .header_i (header_q),
    .offset_o (offset)
  );

  assign done_o          = done_q;
  assign hit_o           = hit_q;
  assign slot_o          = slot_q;
  assign evicted_valid_o = ev_vld_q;
  assign evicted_row_o   = ev_row_q;
  assign fetch_offset_o  = off_q;

  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##3 done_o)
    else $error("result strobe did not follow a request after three cycles");

  a_hit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && hit_o) |-> (!evicted_valid_o && evicted_row_o == '0 && fetch_offset_o == '0))
    else $error("hit result carries eviction or fetch data");

  a_miss_mapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> slot_vld_q[slot_o])
    else $error("allocated slot not marked valid after a miss");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("block not busy after accepting a request");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for fifo_row_line_cache: directed and random row requests are
// checked against a predictor of the row map, the slot map and the line offsets.
// Depends on flrc_pkg and the RTL of the block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import flrc_pkg::*;

  typedef struct packed {
    logic            hit;
    logic [SlotW-1:0] slot;
    logic            ev_valid;
    logic [RowW-1:0]  ev_row;
    logic [OffW-1:0]  offset;
  } line_answer_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [RowW-1:0]    row_i;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_wdata_i;
  logic               done_o;
  logic               hit_o;
  logic [SlotW-1:0]   slot_o;
  logic               evicted_valid_o;
  logic [RowW-1:0]    evicted_row_o;
  logic [OffW-1:0]    fetch_offset_o;

  line_answer_t line_answers[$];
  int           errors = 0;
  int           gap_pct = 0;

  bit               row_held[MaxRows];
  logic [SlotW-1:0] row_where[MaxRows];
  bit               slot_full[MaxSlots];
  logic [RowW-1:0]  slot_holds[MaxSlots];
  int               fill_ptr = 0;

  logic [CntW-1:0]  slots_reg  = CntW'(SlotsRst);
  logic [HdrW-1:0]  header_reg = HdrW'(HdrRst);
  logic [SampW-1:0] sample_reg = SampW'(SampRst);
  logic [LineW-1:0] line_reg   = LineW'(LineRst);

  logic [RowW-1:0]  ws_base;
  int               ws_span;
  logic [RowW-1:0]  scan_row;

  fifo_row_line_cache uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .row_i          (row_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .done_o         (done_o),
    .hit_o          (hit_o),
    .slot_o         (slot_o),
    .evicted_valid_o(evicted_valid_o),
    .evicted_row_o  (evicted_row_o),
    .fetch_offset_o (fetch_offset_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic line_answer_t lookup_row(input logic [RowW-1:0] r);
    line_answer_t res;
    int           eff;
    int           victim;
    logic [63:0]  off;
    res = '0;
    if (row_held[r]) begin
      res.hit  = 1'b1;
      res.slot = row_where[r];
      return res;
    end
    eff = int'(slots_reg);
    if (eff == 0) eff = 1;
    if (eff > MaxSlots) eff = MaxSlots;
    victim = (fill_ptr < eff) ? fill_ptr : 0;
    if (slot_full[victim]) begin
      row_held[slot_holds[victim]] = 1'b0;
      res.ev_valid = 1'b1;
      res.ev_row   = slot_holds[victim];
    end
    row_held[r]        = 1'b1;
    row_where[r]       = SlotW'(victim);
    slot_full[victim]  = 1'b1;
    slot_holds[victim] = r;
    fill_ptr = (victim + 1 >= eff) ? 0 : victim + 1;
    res.slot = SlotW'(victim);
    off = 64'(header_reg) + 64'(sample_reg) * 64'(r) * 64'(line_reg);
    res.offset = (off > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : off[31:0];
    return res;
  endfunction

  task automatic check_field(input string name, input logic [OffW-1:0] want,
                             input logic [OffW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(negedge clk_i) begin : check_answers
    line_answer_t want;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (line_answers.size() == 0) begin
        $display("%0t: result without a pending request, expected none, actual slot %0d",
                 $time, slot_o);
        errors++;
      end else begin
        want = line_answers.pop_front();
        check_field("hit", OffW'(want.hit), OffW'(hit_o));
        check_field("slot", OffW'(want.slot), OffW'(slot_o));
        check_field("evicted_valid", OffW'(want.ev_valid), OffW'(evicted_valid_o));
        check_field("evicted_row", OffW'(want.ev_row), OffW'(evicted_row_o));
        check_field("fetch_offset", want.offset, fetch_offset_o);
      end
    end
  end

  task automatic send_row(input logic [RowW-1:0] r);
    bit           taken;
    line_answer_t want;
    if ($urandom_range(0, 99) < gap_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    row_i   <= r;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end
    want = lookup_row(r);
    line_answers = {line_answers, want};
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    while (line_answers.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CfgSlots:  slots_reg  = data[CntW-1:0];
      CfgHeader: header_reg = data[HdrW-1:0];
      CfgSample: sample_reg = data[SampW-1:0];
      CfgLine:   line_reg   = data[LineW-1:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic pick_config();
    logic [CfgW-1:0] data;
    data = CfgW'($urandom);
    case ($urandom_range(0, 6))
      0: data[CntW-1:0] = 0;
      1: data[CntW-1:0] = 1;
      2: data[CntW-1:0] = 64;
      3: data[CntW-1:0] = CntW'($urandom_range(65, 127));
      4: data[CntW-1:0] = CntW'($urandom_range(2, 8));
      default: data[CntW-1:0] = CntW'($urandom_range(1, 64));
    endcase
    write_reg(CfgSlots, data);
    case ($urandom_range(0, 3))
      0: data = '0;
      1: data = '1;
      default: data = CfgW'($urandom);
    endcase
    write_reg(CfgHeader, data);
    data = CfgW'($urandom);
    case ($urandom_range(0, 4))
      0: data[SampW-1:0] = 0;
      1: data[SampW-1:0] = 1;
      2: data[SampW-1:0] = 8;
      3: data[SampW-1:0] = 15;
      default: ;
    endcase
    write_reg(CfgSample, data);
    data = CfgW'($urandom);
    case ($urandom_range(0, 4))
      0: data[LineW-1:0] = 0;
      1: data[LineW-1:0] = 1;
      2: data[LineW-1:0] = 16'hFFFF;
      default: ;
    endcase
    write_reg(CfgLine, data);
  endtask

  function automatic logic [RowW-1:0] next_row();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return RowW'(ws_base + $urandom_range(0, ws_span));
    if (pick < 85) begin
      scan_row = scan_row + 1'b1;
      return scan_row;
    end
    return RowW'($urandom_range(0, MaxRows - 1));
  endfunction

  task automatic test_reset_defaults();
    send_row(0);
    send_row(12'hFFF);
    send_row(0);
    send_row(1);
  endtask

  task automatic test_fill_and_evict();
    wait_idle();
    write_reg(CfgSlots, 24'd2);
    write_reg(CfgHeader, 24'd512);
    write_reg(CfgSample, 24'd4);
    write_reg(CfgLine, 24'd640);
    send_row(10);
    send_row(11);
    send_row(12);
    send_row(10);
    send_row(12);
  endtask

  task automatic test_slot_count_extremes();
    wait_idle();
    write_reg(CfgSlots, 24'd0);
    send_row(5);
    send_row(6);
    wait_idle();
    write_reg(CfgSlots, 24'd127);
    send_row(7);
  endtask

  task automatic test_pointer_beyond_count();
    wait_idle();
    write_reg(CfgSlots, 24'd64);
    send_row(100);
    send_row(101);
    send_row(102);
    send_row(103);
    wait_idle();
    write_reg(CfgSlots, 24'd3);
    send_row(105);
    send_row(103);
  endtask

  task automatic test_offset_extremes();
    wait_idle();
    write_reg(CfgHeader, 24'hFF_FFFF);
    write_reg(CfgSample, 24'd15);
    write_reg(CfgLine, 24'hFFFF);
    send_row(12'hFFE);
    wait_idle();
    write_reg(CfgSample, 24'd0);
    write_reg(CfgLine, 24'd0);
    send_row(12'hFFD);
  endtask

  task automatic test_random_traffic();
    for (int seg = 0; seg < 6; seg++) begin
      gap_pct = (seg < 2) ? 37 : (seg < 4) ? 51 : 0;
      wait_idle();
      pick_config();
      ws_base  = RowW'($urandom_range(0, MaxRows - 1));
      ws_span  = $urandom_range(1, 96);
      scan_row = RowW'($urandom_range(0, MaxRows - 1));
      for (int i = 0; i < 325; i++) send_row(next_row());
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    row_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CfgSlots;
    cfg_wdata_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(negedge clk_i); while (busy_o !== 1'b0);
    @(posedge clk_i);
    gap_pct = 37;
    test_reset_defaults();
    test_fill_and_evict();
    test_slot_count_extremes();
    test_pointer_beyond_count();
    test_offset_extremes();
    test_random_traffic();
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(3_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== fifo_row_line_cache.f =====
rtl/flrc_pkg.sv
rtl/flrc_ram.sv
rtl/flrc_offset.sv
rtl/fifo_row_line_cache.sv
tb/testbench.sv
